// ===== rtl/mht_pkg.sv =====
// Shared types, codes and helpers for the min-heap timer queue.
package mht_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_SPACE_DEF = 256;

  localparam int CMD_W       = 3;
  localparam int ID_W        = 8;
  localparam int TIMEOUT_W   = 31;
  localparam int TIME_W      = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;
  localparam int ENTRY_W     = ID_W + TIME_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_ADJUST = 3'd1,
    CMD_FIRE   = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_QUERY  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_NEXT  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  // Datapath operation for the current cycle, chosen by the controller.
  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_DISP, OP_RDSLOT, OP_SLOTD, OP_APPEND,
    OP_DN, OP_DNL, OP_DNR, OP_DNCMP, OP_UP, OP_UPCMP, OP_PLACE,
    OP_FEMIT, OP_RM, OP_RMD, OP_TCHK, OP_TCHKD, OP_QANS, OP_CLEAR, OP_DONE
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic known;
    logic in_range;
    logic full;
    logic no_child;
    logic has_right;
    logic child_earlier;
    logic at_root;
    logic beats_parent;
    logic rm_keep;
    logic empty;
    logic due;
    logic moved;
    logic out_free;
  } dp_stat_t;

  // a comes before b when the signed difference is negative.
  function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

// ===== rtl/mht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mht_datapath.sv =====
// Heap storage, id tables, working registers and result register of the timer queue.
module mht_datapath #(
  parameter int CAPACITY = mht_pkg::CAPACITY_DEF,
  parameter int ID_SPACE = mht_pkg::ID_SPACE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mht_pkg::dp_op_t                    op,
  output mht_pkg::dp_stat_t                  stat,
  input  logic [mht_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mht_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [mht_pkg::KIND_W-1:0]         out_tuser,
  output logic                               out_tlast
);
  import mht_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(ID_SPACE);

  logic [CMD_W-1:0]     cmd_r;
  logic [ID_W-1:0]      id_r;
  logic [TIME_W-1:0]    exp_r, now_r;
  logic [AW-1:0]        k_r, c_r;
  logic [TIME_W-1:0]    x_exp_r, ec_exp_r;
  logic [ID_W-1:0]      x_own_r, ec_own_r, rm_own_r;
  logic                 moved_r;
  logic [CW-1:0]        cnt_r;
  logic [ID_SPACE-1:0]  present_r;
  logic [TIMEOUT_W-1:0] rem_r;
  logic [STATUS_W-1:0]  status_r;
  logic                 ov_r;
  logic [OUT_TDATA_W-1:0] od_r;
  logic [KIND_W-1:0]    ou_r;
  logic                 ol_r;

  logic                 h_we;
  logic [AW-1:0]        h_waddr, h_raddr;
  logic [ENTRY_W-1:0]   h_wdata, h_rdata;
  logic                 s_we;
  logic [IW-1:0]        s_waddr, s_raddr;
  logic [AW-1:0]        s_rdata;

  logic [TIME_W-1:0]    rd_exp;
  logic [ID_W-1:0]      rd_own;
  logic [AW+1:0]        child, right, cnt_x;
  logic [AW-1:0]        parent;
  logic [TIME_W-1:0]    due_d;
  logic [IW-1:0]        id_idx;
  logic                 in_range, known, out_free, emit_load;
  logic [OUT_TDATA_W-1:0] emit_data;
  logic [KIND_W-1:0]    emit_kind;

  mht_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  mht_ram #(.WIDTH(AW), .DEPTH(ID_SPACE)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(k_r),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign rd_exp   = h_rdata[TIME_W-1:0];
  assign rd_own   = h_rdata[ENTRY_W-1:TIME_W];
  assign child    = {1'b0, k_r, 1'b1};
  assign right    = child + 1'b1;
  assign cnt_x    = (AW+2)'(cnt_r);
  assign parent   = AW'((k_r - 1'b1) >> 1);
  assign due_d    = rd_exp - now_r;
  assign id_idx   = IW'(id_r);
  assign in_range = int'(id_r) < ID_SPACE;
  assign known    = in_range && present_r[id_idx];
  assign out_free = !ov_r || out_tready;

  always_comb begin
    stat.cmd           = cmd_r;
    stat.known         = known;
    stat.in_range      = in_range;
    stat.full          = int'(cnt_r) >= CAPACITY;
    stat.no_child      = child >= cnt_x;
    stat.has_right     = right < cnt_x;
    stat.child_earlier = earlier(ec_exp_r, x_exp_r);
    stat.at_root       = k_r == '0;
    stat.beats_parent  = earlier(x_exp_r, rd_exp);
    stat.rm_keep       = CW'(k_r) < (cnt_r - 1'b1);
    stat.empty         = cnt_r == '0;
    stat.due           = (due_d == '0) || due_d[TIME_W-1];
    stat.moved         = moved_r;
    stat.out_free      = out_free;
  end

  // Heap and slot table ports.
  always_comb begin
    h_raddr = '0;
    unique case (op)
      OP_DN:   h_raddr = child[AW-1:0];
      OP_DNL:  h_raddr = right[AW-1:0];
      OP_UP:   h_raddr = parent;
      OP_RM:   h_raddr = AW'(cnt_r - 1'b1);
      default: h_raddr = '0;
    endcase
    h_we    = 1'b0;
    h_waddr = k_r;
    h_wdata = {x_own_r, x_exp_r};
    s_we    = 1'b0;
    s_waddr = IW'(x_own_r);
    if (op == OP_DNCMP && stat.child_earlier) begin
      h_we    = 1'b1;
      h_wdata = {ec_own_r, ec_exp_r};
      s_we    = 1'b1;
      s_waddr = IW'(ec_own_r);
    end else if (op == OP_UPCMP && stat.beats_parent) begin
      h_we    = 1'b1;
      h_wdata = h_rdata;
      s_we    = 1'b1;
      s_waddr = IW'(rd_own);
    end else if (op == OP_PLACE) begin
      h_we = 1'b1;
      s_we = 1'b1;
    end
    s_raddr = id_idx;
  end

  // Result item to load into the output register.
  always_comb begin
    emit_load = 1'b0;
    emit_kind = KIND_DONE;
    emit_data = '0;
    unique case (op)
      OP_FEMIT: begin
        emit_load = out_free;
        emit_kind = KIND_FIRED;
        emit_data = OUT_TDATA_W'(rm_own_r);
      end
      OP_QANS: begin
        emit_load = out_free;
        emit_kind = KIND_NEXT;
        emit_data = OUT_TDATA_W'({stat.empty, rem_r, {ID_W{1'b0}}});
      end
      OP_DONE: begin
        emit_load = out_free;
        emit_kind = KIND_DONE;
        emit_data = OUT_TDATA_W'({status_r, 1'b0, {TIMEOUT_W{1'b0}}, {ID_W{1'b0}}});
      end
      default: emit_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      present_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (emit_load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      unique case (op)
        OP_APPEND: begin
          cnt_r             <= cnt_r + 1'b1;
          present_r[id_idx] <= 1'b1;
        end
        OP_RM: begin
          cnt_r                     <= cnt_r - 1'b1;
          present_r[IW'(rm_own_r)] <= 1'b0;
        end
        OP_CLEAR: begin
          cnt_r     <= '0;
          present_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      od_r <= emit_data;
      ou_r <= emit_kind;
      ol_r <= op != OP_FEMIT;
    end
    unique case (op)
      OP_LOAD: begin
        cmd_r <= in_tdata[2:0];
        id_r  <= in_tdata[10:3];
        now_r <= in_tdata[73:42];
        exp_r <= in_tdata[73:42] + TIME_W'(in_tdata[41:11]);
      end
      OP_DISP: begin
        rem_r    <= '0;
        status_r <= STAT_OK;
        if ((cmd_r == CMD_ADD && !in_range) ||
            ((cmd_r == CMD_ADJUST || cmd_r == CMD_FIRE) && !known)) begin
          status_r <= STAT_UNKNOWN;
        end else if (cmd_r == CMD_ADD && !known && stat.full) begin
          status_r <= STAT_FULL;
        end
      end
      OP_SLOTD: begin
        k_r      <= s_rdata;
        moved_r  <= 1'b0;
        x_exp_r  <= exp_r;
        x_own_r  <= id_r;
        rm_own_r <= id_r;
      end
      OP_APPEND: begin
        k_r     <= AW'(cnt_r);
        moved_r <= 1'b0;
        x_exp_r <= exp_r;
        x_own_r <= id_r;
      end
      OP_DNL: begin
        ec_exp_r <= rd_exp;
        ec_own_r <= rd_own;
        c_r      <= child[AW-1:0];
      end
      OP_DNR: begin
        if (earlier(rd_exp, ec_exp_r)) begin
          ec_exp_r <= rd_exp;
          ec_own_r <= rd_own;
          c_r      <= c_r + 1'b1;
        end
      end
      OP_DNCMP: begin
        if (stat.child_earlier) begin
          k_r     <= c_r;
          moved_r <= 1'b1;
        end
      end
      OP_UPCMP: begin
        if (stat.beats_parent) begin
          k_r <= parent;
        end
      end
      OP_RMD: begin
        x_exp_r <= rd_exp;
        x_own_r <= rd_own;
        moved_r <= 1'b0;
      end
      OP_TCHKD: begin
        if (stat.due) begin
          rm_own_r <= rd_own;
          k_r      <= '0;
        end else begin
          rem_r <= due_d[TIMEOUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule

// ===== rtl/mht_ctrl.sv =====
// Command sequencer of the timer queue: one-hot state machine driving the datapath.
module mht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mht_pkg::dp_stat_t stat,
  output mht_pkg::dp_op_t   op
);
  import mht_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001, ST_DISP  = 20'h00002, ST_RDSLOT = 20'h00004,
    ST_SLOTD  = 20'h00008, ST_APPEND = 20'h00010, ST_DN    = 20'h00020,
    ST_DNL    = 20'h00040, ST_DNR   = 20'h00080, ST_DNCMP  = 20'h00100,
    ST_UP     = 20'h00200, ST_UPCMP = 20'h00400, ST_PLACE  = 20'h00800,
    ST_FEMIT  = 20'h01000, ST_RM    = 20'h02000, ST_RMD    = 20'h04000,
    ST_TCHK   = 20'h08000, ST_TCHKD = 20'h10000, ST_QANS   = 20'h20000,
    ST_CLEAR  = 20'h40000, ST_DONE  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_tick, is_query;
  state_t tick_end, sift_end;

  assign is_query  = stat.cmd == CMD_QUERY;
  assign is_tick   = stat.cmd == CMD_TICK || is_query;
  assign tick_end  = is_query ? ST_QANS : ST_DONE;
  assign sift_end  = stat.moved ? ST_PLACE : ST_UP;
  assign in_tready = state_r == ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op        = OP_LOAD;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        op = OP_DISP;
        if (stat.cmd == CMD_ADD) begin
          if (!stat.in_range) begin
            state_nxt = ST_DONE;
          end else if (stat.known) begin
            state_nxt = ST_RDSLOT;
          end else if (stat.full) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_APPEND;
          end
        end else if (stat.cmd == CMD_ADJUST || stat.cmd == CMD_FIRE) begin
          state_nxt = stat.known ? ST_RDSLOT : ST_DONE;
        end else if (is_tick) begin
          state_nxt = ST_TCHK;
        end else if (stat.cmd == CMD_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDSLOT: begin
        op        = OP_RDSLOT;
        state_nxt = ST_SLOTD;
      end
      ST_SLOTD: begin
        op        = OP_SLOTD;
        state_nxt = (stat.cmd == CMD_FIRE) ? ST_FEMIT : ST_DN;
      end
      ST_APPEND: begin
        op        = OP_APPEND;
        state_nxt = ST_DN;
      end
      ST_DN: begin
        op        = OP_DN;
        state_nxt = stat.no_child ? sift_end : ST_DNL;
      end
      ST_DNL: begin
        op        = OP_DNL;
        state_nxt = stat.has_right ? ST_DNR : ST_DNCMP;
      end
      ST_DNR: begin
        op        = OP_DNR;
        state_nxt = ST_DNCMP;
      end
      ST_DNCMP: begin
        op        = OP_DNCMP;
        state_nxt = stat.child_earlier ? ST_DN : sift_end;
      end
      ST_UP: begin
        op        = OP_UP;
        state_nxt = stat.at_root ? ST_PLACE : ST_UPCMP;
      end
      ST_UPCMP: begin
        op        = OP_UPCMP;
        state_nxt = stat.beats_parent ? ST_UP : ST_PLACE;
      end
      ST_PLACE: begin
        op        = OP_PLACE;
        state_nxt = is_tick ? ST_TCHK : ST_DONE;
      end
      ST_FEMIT: begin
        op = OP_FEMIT;
        if (stat.out_free) begin
          state_nxt = ST_RM;
        end
      end
      ST_RM: begin
        op = OP_RM;
        if (stat.rm_keep) begin
          state_nxt = ST_RMD;
        end else begin
          state_nxt = is_tick ? ST_TCHK : ST_DONE;
        end
      end
      ST_RMD: begin
        op        = OP_RMD;
        state_nxt = ST_DN;
      end
      ST_TCHK: begin
        op        = OP_TCHK;
        state_nxt = stat.empty ? tick_end : ST_TCHKD;
      end
      ST_TCHKD: begin
        op        = OP_TCHKD;
        state_nxt = stat.due ? ST_FEMIT : tick_end;
      end
      ST_QANS: begin
        op = OP_QANS;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        op        = OP_CLEAR;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        op = OP_DONE;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        op        = OP_IDLE;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/min_heap_timer_queue_top.sv =====
// Top level of the min-heap timer queue: controller, datapath and stream ports.
// Timing: the done item of a command appears later for each level sifted down or up, and each
// fired timer adds its own removal from the heap before the done item.
// Throughput: one command at a time; the single read port of the heap memory sets the pace.
// Reset: synchronous, active low; empties the queue and the output register at once.
module min_heap_timer_queue_top #(
  parameter int CAPACITY = mht_pkg::CAPACITY_DEF,
  parameter int ID_SPACE = mht_pkg::ID_SPACE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // command[2:0], timer_id[10:3], timeout_ms[41:11], now_ms[73:42], zero fill above
  input  logic [mht_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fired_id[7:0], remaining_ms[38:8], queue_empty[39], status[41:40], zero fill above
  output logic [mht_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [mht_pkg::KIND_W-1:0]      out_tuser,
  // set on the final result item of a command
  output logic                            out_tlast
);
  import mht_pkg::*;

  // Heap and slot memories are not cleared; only entries of present timers are ever used.
  dp_op_t   op;
  dp_stat_t stat;

  // The controller walks each command through its heap operations; the result register in
  // the datapath lets the next command be taken while the final item still waits.
  mht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .op(op)
  );

  mht_datapath #(.CAPACITY(CAPACITY), .ID_SPACE(ID_SPACE)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .stat(stat), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule
